@@ hdl/lcd_nibble_byte_writer_defines.svh @@
`ifndef LCD_NIBBLE_BYTE_WRITER_DEFINES_SVH
`define LCD_NIBBLE_BYTE_WRITER_DEFINES_SVH

// Check a property that holds in the same cycle.
`define LNBW_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Check a property that holds in the cycle after the trigger.
`define LNBW_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

@@ hdl/lnbw_pkg.sv @@
`timescale 1ns / 1ps

package lnbw_pkg;

  typedef enum logic [1:0] {
    ACT_DATA    = 2'd0,
    ACT_COMMAND = 2'd1,
    ACT_NIBBLE  = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    REG_SETUP_HOLD     = 3'd0,
    REG_ENABLE_HIGH    = 3'd1,
    REG_NIBBLE_GAP     = 3'd2,
    REG_DATA_SETTLE    = 3'd3,
    REG_COMMAND_SETTLE = 3'd4
  } reg_index_t;

  typedef enum logic [2:0] {
    STEP_HI_SETUP = 3'd0,
    STEP_HI_EN    = 3'd1,
    STEP_HI_GAP   = 3'd2,
    STEP_LO_SETUP = 3'd3,
    STEP_LO_EN    = 3'd4,
    STEP_LO_GAP   = 3'd5,
    STEP_SETTLE   = 3'd6
  } step_t;

  localparam logic [15:0] SETUP_HOLD_RESET     = 16'd1;
  localparam logic [15:0] ENABLE_HIGH_RESET    = 16'd1;
  localparam logic [15:0] NIBBLE_GAP_RESET     = 16'd100;
  localparam logic [15:0] DATA_SETTLE_RESET    = 16'd250;
  localparam logic [15:0] COMMAND_SETTLE_RESET = 16'd2000;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] value;
    logic       translate;
    logic       nibble_select;
  } req_t;

  typedef struct packed {
    logic        reg_select;
    logic [3:0]  data_pins;
    logic        enable_pin;
    logic [15:0] hold_us;
    logic        last;
  } snap_t;

  typedef struct packed {
    logic [15:0] setup_hold_us;
    logic [15:0] enable_high_us;
    logic [15:0] nibble_gap_us;
    logic [15:0] data_settle_us;
    logic [15:0] command_settle_us;
  } cfg_t;

  typedef struct packed {
    logic  busy;
    step_t step;
    logic  load;
  } seq_status_t;

  function automatic logic [7:0] map_letter(input logic [7:0] c);
    logic [7:0] m;
    case (c)
      8'hF6:   m = 8'hEF;
      8'hE4:   m = 8'hE1;
      8'hE5:   m = 8'h00;
      8'hC5:   m = 8'h01;
      8'hC4:   m = 8'h02;
      8'hD6:   m = 8'h03;
      default: m = c;
    endcase
    return m;
  endfunction

endpackage

@@ hdl/lnbw_cfg.sv @@
`timescale 1ns / 1ps

module lnbw_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output lnbw_pkg::cfg_t     regs
);
  import lnbw_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.setup_hold_us     <= SETUP_HOLD_RESET;
      regs.enable_high_us    <= ENABLE_HIGH_RESET;
      regs.nibble_gap_us     <= NIBBLE_GAP_RESET;
      regs.data_settle_us    <= DATA_SETTLE_RESET;
      regs.command_settle_us <= COMMAND_SETTLE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_SETUP_HOLD:     regs.setup_hold_us     <= cfg_data;
        REG_ENABLE_HIGH:    regs.enable_high_us    <= cfg_data;
        REG_NIBBLE_GAP:     regs.nibble_gap_us     <= cfg_data;
        REG_DATA_SETTLE:    regs.data_settle_us    <= cfg_data;
        REG_COMMAND_SETTLE: regs.command_settle_us <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/lnbw_seq.sv @@
`timescale 1ns / 1ps

module lnbw_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  lnbw_pkg::req_t        req,
  input  lnbw_pkg::cfg_t        regs,
  output logic                  seq_valid,
  output lnbw_pkg::snap_t       seq_snap,
  input  logic                  load,
  output lnbw_pkg::seq_status_t status
);
  import lnbw_pkg::*;

  logic       busy;
  step_t      step;
  logic       rs;
  logic [3:0] hi;
  logic [3:0] lo;
  logic       nibble_only;
  logic       data_byte;

  logic       accept;
  logic       done;
  logic [7:0] mapped;

  assign done      = load && seq_snap.last;
  assign req_stall = busy && !done;
  assign accept    = req_valid && !req_stall;

  always_comb begin
    if (action_t'(req.action) == ACT_DATA && req.translate) begin
      mapped = map_letter(req.value);
    end else begin
      mapped = req.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= STEP_HI_SETUP;
    end else if (accept) begin
      busy <= (action_t'(req.action) != ACT_NONE);
      step <= (action_t'(req.action) == ACT_NIBBLE) ? STEP_LO_SETUP : STEP_HI_SETUP;
    end else if (done) begin
      busy <= 1'b0;
    end else if (load) begin
      step <= step_t'(step + 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rs          <= (action_t'(req.action) == ACT_DATA) ||
                     ((action_t'(req.action) == ACT_NIBBLE) && req.nibble_select);
      hi          <= mapped[7:4];
      lo          <= mapped[3:0];
      nibble_only <= (action_t'(req.action) == ACT_NIBBLE);
      data_byte   <= (action_t'(req.action) == ACT_DATA);
    end
  end

  assign seq_valid = busy;

  always_comb begin
    seq_snap.reg_select = rs;
    seq_snap.data_pins  = (step == STEP_HI_SETUP || step == STEP_HI_EN ||
                           step == STEP_HI_GAP) ? hi : lo;
    seq_snap.enable_pin = (step == STEP_HI_EN || step == STEP_LO_EN);
    seq_snap.last       = (step == STEP_SETTLE) || (nibble_only && step == STEP_LO_GAP);
    case (step)
      STEP_HI_SETUP, STEP_LO_SETUP: seq_snap.hold_us = regs.setup_hold_us;
      STEP_HI_EN, STEP_LO_EN:       seq_snap.hold_us = regs.enable_high_us;
      STEP_HI_GAP, STEP_LO_GAP:     seq_snap.hold_us = regs.nibble_gap_us;
      STEP_SETTLE: begin
        seq_snap.hold_us = data_byte ? regs.data_settle_us : regs.command_settle_us;
      end
      default:                      seq_snap.hold_us = '0;
    endcase
  end

  assign status.busy = busy;
  assign status.step = step;
  assign status.load = load;

endmodule

@@ hdl/lnbw_out_reg.sv @@
`timescale 1ns / 1ps

module lnbw_out_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            seq_valid,
  input  lnbw_pkg::snap_t seq_snap,
  output logic            load,
  output logic            snap_valid,
  input  logic            snap_stall,
  output lnbw_pkg::snap_t snap
);
  import lnbw_pkg::*;

  assign load = seq_valid && (!snap_valid || !snap_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (load) begin
      snap_valid <= 1'b1;
    end else if (!snap_stall) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      snap <= seq_snap;
    end
  end

endmodule

@@ hdl/lcd_nibble_byte_writer.sv @@
`timescale 1ns / 1ps
// Character-LCD 4-bit write sequencer.
// Request channel (req_valid, req_stall, req): one beat is a data byte, a command
// byte or a single raw nibble. Action code 3 is taken and dropped without output.
// Snapshot channel (snap_valid, snap_stall, snap): one beat is one pin state with
// its hold time; last marks the final beat of a request.
// Config channel (cfg_valid, cfg_ready, cfg_index, cfg_data): writes one of the five
// timing registers; always ready; indexes above 4 are ignored. Write only when idle.
// On acceptance the request is registered in the sequencer; the first snapshot then
// moves into the output register. A byte yields seven snapshots, a nibble three,
// one per cycle while the output register is not held by snap_stall. The next
// request is taken in the cycle the last snapshot of the current one moves into
// the output register.
// When snap_stall is high while snap_valid is high, the output register holds its beat,
// the sequencer holds its step and req_stall stays high until the last snapshot is loaded.
// Reset (rst, synchronous): drops any request in flight, empties the output register
// and restores the timing registers to 1, 1, 100, 250 and 2000 us.
module lcd_nibble_byte_writer (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  lnbw_pkg::req_t  req,
  output logic            snap_valid,
  input  logic            snap_stall,
  output lnbw_pkg::snap_t snap,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [15:0]     cfg_data
);
  import lnbw_pkg::*;

  `include "lcd_nibble_byte_writer_defines.svh"

  cfg_t        regs;
  logic        seq_valid;
  snap_t       seq_snap;
  logic        load;
  seq_status_t status;

  lnbw_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  lnbw_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .regs      (regs),
    .seq_valid (seq_valid),
    .seq_snap  (seq_snap),
    .load      (load),
    .status    (status)
  );

  lnbw_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .seq_valid  (seq_valid),
    .seq_snap   (seq_snap),
    .load       (load),
    .snap_valid (snap_valid),
    .snap_stall (snap_stall),
    .snap       (snap)
  );

  `LNBW_ASSERT_NOW(a_step_range, status.busy, status.step <= STEP_SETTLE, "step out of range")
  `LNBW_ASSERT_NEXT(a_req_starts, req_valid && !req_stall && req.action != ACT_NONE, status.busy, "accepted request did not start")
  `LNBW_ASSERT_NEXT(a_load_fills, status.load, snap_valid, "loaded snapshot not presented")
  `LNBW_ASSERT_NOW(a_stall_while_busy, status.busy && !status.load, req_stall, "request taken mid-sequence")

endmodule

@@ verif/lcd_pin_checker.sv @@
`timescale 1ns / 1ps

module lcd_pin_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic            req_stall,
  input  lnbw_pkg::req_t  req,
  input  logic            snap_valid,
  input  logic            snap_stall,
  input  lnbw_pkg::snap_t snap,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [15:0]     cfg_data,
  output int              fails,
  output int              snaps_due,
  output int              snaps_checked
);
  import lnbw_pkg::*;

  cfg_t  timing;
  snap_t pins_due_q[$];

  function automatic logic [7:0] glyph_code(input logic [7:0] c);
    logic [7:0] g;
    case (c)
      8'hF6:   g = 8'hEF;
      8'hE4:   g = 8'hE1;
      8'hE5:   g = 8'h00;
      8'hC5:   g = 8'h01;
      8'hC4:   g = 8'h02;
      8'hD6:   g = 8'h03;
      default: g = c;
    endcase
    return g;
  endfunction

  function automatic void queue_nibble(input logic rs, input logic [3:0] nib, input logic fin);
    pins_due_q.push_back(snap_t'{rs, nib, 1'b0, timing.setup_hold_us, 1'b0});
    pins_due_q.push_back(snap_t'{rs, nib, 1'b1, timing.enable_high_us, 1'b0});
    pins_due_q.push_back(snap_t'{rs, nib, 1'b0, timing.nibble_gap_us, fin});
  endfunction

  function automatic void predict_pins(input req_t r);
    logic        rs;
    logic [7:0]  b;
    logic [15:0] settle;
    case (action_t'(r.action))
      ACT_NIBBLE: begin
        queue_nibble(r.nibble_select, r.value[3:0], 1'b1);
      end
      ACT_DATA, ACT_COMMAND: begin
        rs = (r.action == ACT_DATA);
        b = (rs && r.translate) ? glyph_code(r.value) : r.value;
        settle = rs ? timing.data_settle_us : timing.command_settle_us;
        queue_nibble(rs, b[7:4], 1'b0);
        queue_nibble(rs, b[3:0], 1'b0);
        pins_due_q.push_back(snap_t'{rs, b[3:0], 1'b0, settle, 1'b1});
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    snap_t want;
    if (rst) begin
      timing = cfg_t'{SETUP_HOLD_RESET, ENABLE_HIGH_RESET, NIBBLE_GAP_RESET,
                      DATA_SETTLE_RESET, COMMAND_SETTLE_RESET};
      pins_due_q.delete();
    end else begin
      if (snap_valid && !snap_stall) begin
        snaps_checked++;
        if (pins_due_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: pin beat with nothing due: rs=%b d=%h en=%b hold=%0d last=%b",
                     $realtime, snap.reg_select, snap.data_pins, snap.enable_pin,
                     snap.hold_us, snap.last);
        end else begin
          want = pins_due_q.pop_front();
          if (snap.reg_select !== want.reg_select || snap.data_pins !== want.data_pins ||
              snap.enable_pin !== want.enable_pin || snap.hold_us !== want.hold_us ||
              snap.last !== want.last) begin
            fails++;
            if (fails <= 10) begin
              $display("%0t: pin beat mismatch: want rs=%b d=%h en=%b hold=%0d last=%b",
                       $realtime, want.reg_select, want.data_pins, want.enable_pin,
                       want.hold_us, want.last);
              $display("%0t:                     got rs=%b d=%h en=%b hold=%0d last=%b",
                       $realtime, snap.reg_select, snap.data_pins, snap.enable_pin,
                       snap.hold_us, snap.last);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (reg_index_t'(cfg_index))
          REG_SETUP_HOLD:     timing.setup_hold_us = cfg_data;
          REG_ENABLE_HIGH:    timing.enable_high_us = cfg_data;
          REG_NIBBLE_GAP:     timing.nibble_gap_us = cfg_data;
          REG_DATA_SETTLE:    timing.data_settle_us = cfg_data;
          REG_COMMAND_SETTLE: timing.command_settle_us = cfg_data;
          default: ;
        endcase
      end
      if (req_valid && !req_stall)
        predict_pins(req);
    end
    snaps_due = pins_due_q.size();
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import lnbw_pkg::*;

  localparam int          DRAIN_CYCLES      = 8;
  localparam int          HOLD_OFF_CYCLES   = 90;
  localparam int          RANDOM_PER_PHASE  = 37;
  localparam longint      RUN_LIMIT_NS      = 2000000;
  localparam logic [2:0]  FIRST_SPARE_INDEX = 3'd5;
  localparam logic [2:0]  LAST_SPARE_INDEX  = 3'd7;
  localparam logic [7:0]  SWEDISH_LETTERS [6] = '{8'hF6, 8'hE4, 8'hE5, 8'hC5, 8'hC4, 8'hD6};

  logic        clk = 1'b0;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  req_t        req_beat;
  logic        snap_valid;
  logic        snap_stall;
  snap_t       snap_beat;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  int fails;
  int snaps_due;
  int snaps_checked;
  int act_count[4];
  int settings_used;
  int rx_hold_req;
  bit src_idle;
  bit rx_idle;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  lcd_nibble_byte_writer i_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req_beat),
    .snap_valid (snap_valid),
    .snap_stall (snap_stall),
    .snap       (snap_beat),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  lcd_pin_checker i_pin_checker (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req           (req_beat),
    .snap_valid    (snap_valid),
    .snap_stall    (snap_stall),
    .snap          (snap_beat),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fails         (fails),
    .snaps_due     (snaps_due),
    .snaps_checked (snaps_checked)
  );

  function automatic req_t mk_req(input action_t a, input logic [7:0] v, input logic tr,
                                  input logic ns);
    req_t r;
    r.action = a;
    r.value = v;
    r.translate = tr;
    r.nibble_select = ns;
    return r;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int   pick;
    pick = $urandom_range(0, 19);
    r.action = (pick < 8) ? ACT_DATA : (pick < 13) ? ACT_COMMAND :
               (pick < 18) ? ACT_NIBBLE : ACT_NONE;
    r.value = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0)
      r.value = SWEDISH_LETTERS[3'($urandom_range(0, 5))];
    r.translate = 1'($urandom_range(0, 1));
    r.nibble_select = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic logic [15:0] rand_hold();
    logic [15:0] h;
    case ($urandom_range(0, 3))
      0:       h = 16'h0000;
      1:       h = 16'hFFFF;
      default: h = 16'($urandom_range(0, 65535));
    endcase
    return h;
  endfunction

  task automatic send_req(input req_t r);
    @(negedge clk);
    if (src_idle && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    req_valid <= 1'b1;
    req_beat <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    act_count[r.action]++;
  endtask

  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (snaps_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_timing(input cfg_t t);
    write_reg(REG_SETUP_HOLD, t.setup_hold_us);
    write_reg(REG_ENABLE_HIGH, t.enable_high_us);
    write_reg(REG_NIBBLE_GAP, t.nibble_gap_us);
    write_reg(REG_DATA_SETTLE, t.data_settle_us);
    write_reg(REG_COMMAND_SETTLE, t.command_settle_us);
    write_reg(3'($urandom_range(FIRST_SPARE_INDEX, LAST_SPARE_INDEX)),
              16'($urandom_range(0, 65535)));
    settings_used++;
  endtask

  task automatic run_random(input int n, input int hold_at);
    for (int k = 0; k < n; k++) begin
      if (k == hold_at)
        rx_hold_req = HOLD_OFF_CYCLES;
      send_req(rand_req());
    end
    drain();
  endtask

  // receiver side: random stall bursts plus one long hold-off on request
  initial begin
    snap_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req != 0) begin
        snap_stall <= 1'b1;
        repeat (rx_hold_req) @(negedge clk);
        rx_hold_req = 0;
        snap_stall <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 5) == 0) begin
        snap_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        snap_stall <= 1'b0;
      end
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("lcd_nibble_byte_writer test failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req_beat = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_SETUP_HOLD;
    cfg_data = '0;
    src_idle = 1'b1;
    rx_idle = 1'b1;
    rx_hold_req = 0;
    settings_used = 1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset timing values
    send_req(mk_req(ACT_DATA, 8'h00, 1'b0, 1'b0));
    send_req(mk_req(ACT_DATA, 8'hFF, 1'b1, 1'b1));
    send_req(mk_req(ACT_COMMAND, 8'h00, 1'b0, 1'b1));
    send_req(mk_req(ACT_COMMAND, 8'hFF, 1'b0, 1'b0));
    send_req(mk_req(ACT_NIBBLE, 8'hF0, 1'b0, 1'b0));
    send_req(mk_req(ACT_NIBBLE, 8'h0F, 1'b0, 1'b1));
    send_req(mk_req(ACT_NIBBLE, 8'hF6, 1'b1, 1'b1));
    for (int k = 0; k < 6; k++)
      send_req(mk_req(ACT_DATA, SWEDISH_LETTERS[k], 1'b1, 1'b0));
    send_req(mk_req(ACT_DATA, 8'hF6, 1'b0, 1'b1));
    send_req(mk_req(ACT_DATA, 8'hEF, 1'b1, 1'b0));
    send_req(mk_req(ACT_DATA, 8'h41, 1'b1, 1'b0));
    send_req(mk_req(ACT_COMMAND, 8'hC5, 1'b1, 1'b1));
    send_req(mk_req(ACT_NONE, 8'hFF, 1'b1, 1'b1));
    send_req(mk_req(ACT_DATA, 8'h5A, 1'b0, 1'b0));
    send_req(mk_req(ACT_NONE, 8'h00, 1'b0, 1'b0));
    send_req(mk_req(ACT_NONE, 8'hA5, 1'b1, 1'b0));
    send_req(mk_req(ACT_COMMAND, 8'hA5, 1'b0, 1'b0));
    drain();

    program_timing(cfg_t'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
    run_random(RANDOM_PER_PHASE, 8);
    program_timing(cfg_t'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    run_random(RANDOM_PER_PHASE, -1);
    program_timing(cfg_t'{rand_hold(), rand_hold(), rand_hold(), rand_hold(), rand_hold()});
    run_random(RANDOM_PER_PHASE, -1);

    // back to back, no idling
    src_idle = 1'b0;
    rx_idle = 1'b0;
    program_timing(cfg_t'{rand_hold(), rand_hold(), rand_hold(), rand_hold(), rand_hold()});
    run_random(RANDOM_PER_PHASE, -1);

    $display("Covered %0d data, %0d command, %0d nibble and %0d undefined requests",
             act_count[ACT_DATA], act_count[ACT_COMMAND], act_count[ACT_NIBBLE],
             act_count[ACT_NONE]);
    $display("over %0d timing settings and a long output hold-off; %0d pin beats compared.",
             settings_used, snaps_checked);
    if (fails == 0)
      $display("lcd_nibble_byte_writer test passed");
    else
      $display("lcd_nibble_byte_writer test failed");
    $finish;
  end

endmodule
